[hdl/wtmp_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// wtmp_pkg: shared definitions for the windowed trace mean or peak unit
// Register indexes, reset values, sizing defaults and the sequencer states.
// ============================================================================
package wtmp_pkg;

    localparam int MAX_SAMPLES_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int SAMPLE_W = 24;
    localparam int LEVEL_W  = 64;
    localparam int WIN_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PEAK_MODE  = 3'd0,
        REG_EXPONENT   = 3'd1,
        REG_TAKE_ROOT  = 3'd2,
        REG_TAKE_RECIP = 3'd3,
        REG_USE_MAG    = 3'd4,
        REG_WIN_FIRST  = 3'd5,
        REG_WIN_LAST   = 3'd6
    } t_reg_idx;

    localparam logic [1:0]       EXPONENT_RST  = 2'd2;
    localparam logic [1:0]       EXPONENT_LIN  = 2'd1;
    localparam logic [WIN_W-1:0] WIN_FIRST_RST = 12'd0;
    localparam logic [WIN_W-1:0] WIN_LAST_RST  = 12'd4095;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_FIN,
        ST_DIV,
        ST_ROOT_CHK,
        ST_SQRT,
        ST_REC_CHK,
        ST_RDIV,
        ST_OUT
    } t_state;

endpackage

[hdl/windowed_trace_mean_or_peak_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// windowed_trace_mean_or_peak_unit: per-trace mean, RMS or peak level
// Accumulates windowed samples, then divides, takes roots and reciprocals
// with one shared restoring divider and a bit-pair square root sequencer.
// ============================================================================
// Each sample item passes through accept, square and accumulate states. The item
// that ends a trace adds the end-of-trace work: the mean division and the
// reciprocal each run on the shared one-bit-per-cycle divider, and the square
// root runs two bits a cycle. Input is stalled throughout, and a result waits
// in the output register until taken.
module windowed_trace_mean_or_peak_unit #(
    parameter int MAX_SAMPLES   = wtmp_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS   = wtmp_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = wtmp_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [wtmp_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                                 i_trace_end,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [wtmp_pkg::LEVEL_W-1:0]  o_trace_level,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wtmp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wtmp_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int FB    = FRACTION_BITS;
    localparam int POS_W = $clog2(MAX_SAMPLES + 1);
    localparam int CW    = (POS_W > wtmp_pkg::WIN_W) ? POS_W : wtmp_pkg::WIN_W;
    localparam int DW    = 64 + FB;
    localparam int NP    = (65 + FB) / 2;
    localparam int SW    = 2 * NP;
    localparam int IT_W  = $clog2(DW + 1);
    localparam logic [63:0] SAT_Q  = 64'h7FFF_FFFF_FFFF_FFFF >> FB;
    localparam logic [63:0] INT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SAMPLES);

    wtmp_pkg::t_state r_state, n_state;

    logic                          r_peak_mode, r_take_root, r_take_recip, r_use_mag;
    logic [1:0]                    r_exponent;
    logic [wtmp_pkg::WIN_W-1:0]    r_win_first, r_win_last;

    logic [SB-1:0]                 r_smp;
    logic                          r_end;
    logic signed [SB:0]            r_v;
    logic [63:0]                   r_term;
    logic                          r_use;
    logic [POS_W-1:0]              r_pos;
    logic [63:0]                   r_sum;
    logic [POS_W-1:0]              r_cnt;
    logic [SB-1:0]                 r_peak;

    logic [63:0]                   r_level;
    logic                          r_neg;
    logic                          r_mean_div;

    logic [DW-1:0]                 r_dq;
    logic [63:0]                   r_rem;
    logic [63:0]                   r_dsr;
    logic [IT_W-1:0]               r_iter;

    logic [SW-1:0]                 r_sv;
    logic [NP+1:0]                 r_srem;
    logic [NP-1:0]                 r_root;

    logic                          r_out_valid;
    logic [63:0]                   r_out;

    logic signed [SB:0]            s_ext;
    logic signed [SB:0]            v_comb;
    logic signed [2*SB+1:0]        v_sq;
    logic [CW-1:0]                 pos_c;
    logic                          use_comb;
    logic [64:0]                   div_t;
    logic                          div_ge;
    logic [NP+3:0]                 sq_t;
    logic [NP+3:0]                 sq_trial;
    logic                          sq_ge;
    logic [63:0]                   sum_mag;
    logic                          out_free;
    logic                          in_acc;

    assign s_ext   = {r_smp[SB-1], r_smp};
    assign v_comb  = (r_use_mag && s_ext < 0) ? -s_ext : s_ext;
    assign v_sq    = v_comb * v_comb;
    assign pos_c   = CW'(r_pos);
    assign use_comb = (r_pos < POS_MAX) && (pos_c >= CW'(r_win_first))
                    && (pos_c <= CW'(r_win_last)) && (s_ext != '0);

    assign div_t  = {r_rem, r_dq[DW-1]};
    assign div_ge = div_t >= {1'b0, r_dsr};

    assign sq_t     = {r_srem, r_sv[SW-1 -: 2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    assign sum_mag  = r_sum[63] ? (64'd0 - r_sum) : r_sum;
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_acc   = i_in_valid && (r_state == wtmp_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wtmp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = wtmp_pkg::ST_MUL;
                end
            end
            wtmp_pkg::ST_MUL: n_state = wtmp_pkg::ST_ACC;
            wtmp_pkg::ST_ACC: begin
                n_state = r_end ? wtmp_pkg::ST_FIN : wtmp_pkg::ST_IDLE;
            end
            wtmp_pkg::ST_FIN: begin
                if (r_peak_mode) begin
                    n_state = wtmp_pkg::ST_REC_CHK;
                end else if (r_cnt == '0) begin
                    n_state = wtmp_pkg::ST_ROOT_CHK;
                end else begin
                    n_state = wtmp_pkg::ST_DIV;
                end
            end
            wtmp_pkg::ST_DIV: begin
                if (r_iter == IT_W'(1)) begin
                    n_state = r_mean_div ? wtmp_pkg::ST_ROOT_CHK : wtmp_pkg::ST_OUT;
                end
            end
            wtmp_pkg::ST_ROOT_CHK: begin
                n_state = r_take_root ? wtmp_pkg::ST_SQRT : wtmp_pkg::ST_REC_CHK;
            end
            wtmp_pkg::ST_SQRT: begin
                if (r_iter == IT_W'(1)) begin
                    n_state = wtmp_pkg::ST_REC_CHK;
                end
            end
            wtmp_pkg::ST_REC_CHK: begin
                n_state = (r_take_recip && r_level != '0) ? wtmp_pkg::ST_RDIV
                                                         : wtmp_pkg::ST_OUT;
            end
            wtmp_pkg::ST_RDIV: begin
                if (r_iter == IT_W'(1)) begin
                    n_state = wtmp_pkg::ST_OUT;
                end
            end
            wtmp_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = wtmp_pkg::ST_IDLE;
                end
            end
            default: n_state = wtmp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall    = (r_state != wtmp_pkg::ST_IDLE);
        o_cfg_ready   = 1'b1;
        o_out_valid   = r_out_valid;
        o_trace_level = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= wtmp_pkg::ST_IDLE;
            r_peak_mode  <= 1'b0;
            r_exponent   <= wtmp_pkg::EXPONENT_RST;
            r_take_root  <= 1'b1;
            r_take_recip <= 1'b0;
            r_use_mag    <= 1'b0;
            r_win_first  <= wtmp_pkg::WIN_FIRST_RST;
            r_win_last   <= wtmp_pkg::WIN_LAST_RST;
            r_pos        <= '0;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_peak       <= '0;
            r_out_valid  <= 1'b0;
            r_iter       <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    wtmp_pkg::REG_PEAK_MODE:  r_peak_mode  <= i_cfg_data[0];
                    wtmp_pkg::REG_EXPONENT:   r_exponent   <= i_cfg_data[1:0];
                    wtmp_pkg::REG_TAKE_ROOT:  r_take_root  <= i_cfg_data[0];
                    wtmp_pkg::REG_TAKE_RECIP: r_take_recip <= i_cfg_data[0];
                    wtmp_pkg::REG_USE_MAG:    r_use_mag    <= i_cfg_data[0];
                    wtmp_pkg::REG_WIN_FIRST:  r_win_first  <= i_cfg_data;
                    wtmp_pkg::REG_WIN_LAST:   r_win_last   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == wtmp_pkg::ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (in_acc) begin
                r_smp <= i_sample_value[SB-1:0];
                r_end <= i_trace_end;
            end

            unique case (r_state)
                wtmp_pkg::ST_MUL: begin
                    r_v    <= v_comb;
                    r_use  <= use_comb;
                    r_term <= (r_exponent == wtmp_pkg::EXPONENT_LIN) ? 64'(v_comb)
                                                                     : 64'(v_sq);
                end
                wtmp_pkg::ST_ACC: begin
                    if (r_use) begin
                        r_sum <= r_sum + r_term;
                        r_cnt <= r_cnt + POS_W'(1);
                        if (r_v > 0 && r_v[SB-1:0] > r_peak) begin
                            r_peak <= r_v[SB-1:0];
                        end
                    end
                    if (r_pos < POS_MAX) begin
                        r_pos <= r_pos + POS_W'(1);
                    end
                end
                wtmp_pkg::ST_FIN: begin
                    r_mean_div <= (r_cnt != '0);
                    if (r_peak_mode) begin
                        r_neg   <= 1'b0;
                        r_level <= 64'(r_peak) << FB;
                    end else begin
                        r_neg   <= r_sum[63];
                        r_level <= '0;
                        r_dq    <= DW'(sum_mag) << FB;
                        r_rem   <= '0;
                        r_dsr   <= 64'(r_cnt);
                        r_iter  <= IT_W'(DW);
                    end
                end
                wtmp_pkg::ST_DIV, wtmp_pkg::ST_RDIV: begin
                    r_rem  <= div_ge ? 64'(div_t - {1'b0, r_dsr}) : div_t[63:0];
                    r_dq   <= {r_dq[DW-2:0], div_ge};
                    r_iter <= r_iter - IT_W'(1);
                end
                wtmp_pkg::ST_ROOT_CHK: begin
                    if (r_mean_div) begin
                        if (r_dq[DW-1:FB] > SAT_Q) begin
                            r_level <= INT_MAX;
                        end else begin
                            r_level <= r_dq[63:0];
                            if (r_dq[63:0] == '0) begin
                                r_neg <= 1'b0;
                            end
                        end
                    end
                    r_mean_div <= 1'b0;
                    if (r_take_root) begin
                        r_sv   <= SW'(r_mean_div ? ((r_dq[DW-1:FB] > SAT_Q) ? INT_MAX
                                                                        : r_dq[63:0])
                                                 : r_level) << FB;
                        r_srem <= '0;
                        r_root <= '0;
                        r_iter <= IT_W'(NP);
                    end
                end
                wtmp_pkg::ST_SQRT: begin
                    r_srem <= sq_ge ? (NP+2)'(sq_t - sq_trial) : sq_t[NP+1:0];
                    r_root <= {r_root[NP-2:0], sq_ge};
                    r_sv   <= r_sv << 2;
                    r_iter <= r_iter - IT_W'(1);
                    if (r_iter == IT_W'(1)) begin
                        r_level <= 64'({r_root[NP-2:0], sq_ge});
                        r_neg   <= 1'b0;
                    end
                end
                wtmp_pkg::ST_REC_CHK: begin
                    r_dq   <= DW'(1) << (2 * FB);
                    r_rem  <= '0;
                    r_dsr  <= r_level;
                    r_iter <= IT_W'(DW);
                end
                wtmp_pkg::ST_OUT: begin
                    if (out_free) begin
                        r_out  <= r_neg ? (64'd0 - r_level) : r_level;
                        r_pos  <= '0;
                        r_sum  <= '0;
                        r_cnt  <= '0;
                        r_peak <= '0;
                    end
                end
                default: ;
            endcase

            if (r_state == wtmp_pkg::ST_RDIV && r_iter == IT_W'(1)) begin
                r_level <= {r_dq[62:0], div_ge};
            end
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for windowed_trace_mean_or_peak_unit
// Streams sample traces with bursty input and random output stall, predicts
// each trace level (mean, root, peak, reciprocal) and checks every result.
// ============================================================================
module tb;

    localparam int  MAXPOS = wtmp_pkg::MAX_SAMPLES_DEF;
    localparam int  FRAC   = wtmp_pkg::FRACTION_BITS_DEF;
    localparam int  SMP_W  = wtmp_pkg::SAMPLE_W;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [wtmp_pkg::SAMPLE_W-1:0] sample;
        bit                                   last;
        bit                                   known;
        logic [wtmp_pkg::LEVEL_W-1:0]         level;
    } t_row;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_stall;
    logic signed [wtmp_pkg::SAMPLE_W-1:0] i_sample_value;
    logic                                 i_trace_end;
    logic                                 o_out_valid;
    logic                                 i_out_stall;
    logic signed [wtmp_pkg::LEVEL_W-1:0]  o_trace_level;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [wtmp_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [wtmp_pkg::CFG_DAT_W-1:0]       i_cfg_data;

    windowed_trace_mean_or_peak_unit DUT (.*);

    bit                         cfg_peak, cfg_root, cfg_recip, cfg_mag;
    logic [1:0]                 cfg_exp;
    logic [wtmp_pkg::WIN_W-1:0] cfg_first, cfg_last;
    int                         trace_pos, used_cnt;
    logic [63:0]                power_sum;
    longint                     peak_val;

    logic [wtmp_pkg::LEVEL_W-1:0] level_q[$];
    int     mismatches;
    int     items_sent;
    int     burst_left;
    bit     hold_req;
    longint cycles;
    t_row   rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] fixed_sqrt(input logic [63:0] m);
        logic [127:0] n;
        logic [129:0] rem;
        logic [129:0] trial;
        logic [63:0]  root;
        n    = {64'd0, m} << FRAC;
        rem  = '0;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            rem   = (rem << 2) | ((n >> (2 * i)) & 128'd3);
            trial = ({66'd0, root} << 2) | 130'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic void clear_trace();
        trace_pos = 0;
        used_cnt  = 0;
        power_sum = '0;
        peak_val  = 0;
    endfunction

    function automatic bit predict_trace_level(
            input logic signed [wtmp_pkg::SAMPLE_W-1:0] s,
            input bit last,
            output logic [63:0] lvl);
        longint      v;
        bit          neg;
        logic [63:0] mag, q, r, level;
        v = longint'(s);
        if (trace_pos < MAXPOS && trace_pos >= cfg_first && trace_pos <= cfg_last
                && v != 0) begin
            if (cfg_mag && v < 0) v = -v;
            power_sum = power_sum + ((cfg_exp == wtmp_pkg::EXPONENT_LIN) ? v : v * v);
            used_cnt++;
            if (v > peak_val) peak_val = v;
        end
        if (trace_pos < MAXPOS) trace_pos++;
        if (!last) return 0;
        neg   = 0;
        level = '0;
        if (cfg_peak) begin
            level = 64'(peak_val) << FRAC;
        end else begin
            if (used_cnt != 0) begin
                mag = power_sum[63] ? -power_sum : power_sum;
                q   = mag / used_cnt;
                r   = mag % used_cnt;
                if (q > (64'h7fff_ffff_ffff_ffff >> FRAC)) level = 64'h7fff_ffff_ffff_ffff;
                else level = (q << FRAC) + ((r << FRAC) / used_cnt);
                neg = power_sum[63] && level != 0;
            end
            if (cfg_root) begin
                level = fixed_sqrt(level);
                neg   = 0;
            end
        end
        if (cfg_recip && level != 0) level = (64'd1 << (2 * FRAC)) / level;
        lvl = (neg && level != 0) ? -level : level;
        clear_trace();
        return 1;
    endfunction

    task automatic write_reg(input wtmp_pkg::t_reg_idx idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[wtmp_pkg::CFG_DAT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            wtmp_pkg::REG_PEAK_MODE:  cfg_peak  = value[0];
            wtmp_pkg::REG_EXPONENT:   cfg_exp   = value[1:0];
            wtmp_pkg::REG_TAKE_ROOT:  cfg_root  = value[0];
            wtmp_pkg::REG_TAKE_RECIP: cfg_recip = value[0];
            wtmp_pkg::REG_USE_MAG:    cfg_mag   = value[0];
            wtmp_pkg::REG_WIN_FIRST:  cfg_first = value[wtmp_pkg::WIN_W-1:0];
            wtmp_pkg::REG_WIN_LAST:   cfg_last  = value[wtmp_pkg::WIN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_all(input int pk, input int ex, input int rt, input int rc,
                           input int mg, input int wf, input int wl);
        write_reg(wtmp_pkg::REG_PEAK_MODE, pk);
        write_reg(wtmp_pkg::REG_EXPONENT, ex);
        write_reg(wtmp_pkg::REG_TAKE_ROOT, rt);
        write_reg(wtmp_pkg::REG_TAKE_RECIP, rc);
        write_reg(wtmp_pkg::REG_USE_MAG, mg);
        write_reg(wtmp_pkg::REG_WIN_FIRST, wf);
        write_reg(wtmp_pkg::REG_WIN_LAST, wl);
    endtask

    task automatic drain();
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic signed [wtmp_pkg::SAMPLE_W-1:0] s,
                               input bit last,
                               input bit known, input logic [63:0] typed);
        logic [63:0] lvl;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_sample_value <= s;
        i_trace_end    <= last;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (predict_trace_level(s, last, lvl)) begin
            level_q.push_back(known ? typed : lvl);
        end
    endtask

    task automatic idle_input();
        i_in_valid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic signed [wtmp_pkg::SAMPLE_W-1:0] rand_sample();
        logic [31:0] rnd;
        rnd = $urandom();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 24'sh800000;
            2:       return 24'sh7fffff;
            3, 4:    return SMP_W'($signed($urandom_range(0, 200)) - 100);
            default: return rnd[wtmp_pkg::SAMPLE_W-1:0];
        endcase
    endfunction

    task automatic send_trace(input int len);
        for (int k = 0; k < len; k++) send_sample(rand_sample(), k == len - 1, 0, '0);
    endtask

    task automatic random_config();
        int wf, wl;
        wf = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 8);
        wl = ($urandom_range(0, 4) == 0) ? 4095 : wf + $urandom_range(0, 30) - 2;
        if (wl < 0) wl = 0;
        if (wl > 4095) wl = 4095;
        set_all($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 1),
                $urandom_range(0, 1), $urandom_range(0, 1), wf, wl);
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            int mode, span;
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 60);
            repeat (span) begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 9) < 3);
                    default: i_out_stall <= ($urandom_range(0, 9) < 8);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (level_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected trace level %h", o_trace_level);
            end else begin
                logic [63:0] want;
                want = level_q.pop_front();
                if (o_trace_level !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("trace level: expected %h, got %h", want, o_trace_level);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [63:0] lvl;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_sample_value = '0;
        i_trace_end    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = wtmp_pkg::REG_PEAK_MODE;
        i_cfg_data     = '0;
        mismatches = 0;
        items_sent = 0;
        burst_left = 0;
        hold_req   = 0;
        cycles     = 0;
        cfg_peak = 0; cfg_exp = wtmp_pkg::EXPONENT_RST; cfg_root = 1; cfg_recip = 0;
        cfg_mag = 0;
        cfg_first = wtmp_pkg::WIN_FIRST_RST; cfg_last = wtmp_pkg::WIN_LAST_RST;
        clear_trace();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back('{24'sd3, 1, 1, 64'd196608});
        rows.push_back('{24'sd0, 1, 1, 64'd0});
        rows.push_back('{24'sh800000, 1, 1, 64'd1 << 39});
        rows.push_back('{24'sh7fffff, 1, 0, '0});
        rows.push_back('{24'sd0, 0, 0, '0});
        rows.push_back('{-24'sd5, 0, 0, '0});
        rows.push_back('{24'sd7, 1, 0, '0});
        rows.push_back('{24'sh800000, 0, 0, '0});
        rows.push_back('{24'sh7fffff, 0, 0, '0});
        rows.push_back('{24'sd1, 1, 0, '0});
        foreach (rows[i]) send_sample(rows[i].sample, rows[i].last, rows[i].known,
                                      rows[i].level);
        idle_input();
        drain();

        set_all(0, 1, 0, 1, 0, 0, 4095);
        send_sample(-24'sd4, 0, 0, '0);
        send_sample(24'sd2, 1, 0, '0);
        send_sample(24'sh800000, 1, 0, '0);
        idle_input(); drain();
        set_all(0, 0, 0, 0, 1, 0, 4095);
        send_sample(-24'sd9, 1, 0, '0);
        idle_input(); drain();
        write_reg(wtmp_pkg::REG_EXPONENT, 3);
        send_sample(-24'sd9, 1, 0, '0);
        idle_input(); drain();
        set_all(1, 1, 1, 0, 0, 0, 4095);
        send_sample(-24'sd9, 0, 0, '0);
        send_sample(-24'sd1, 1, 0, '0);
        send_sample(24'sh7fffff, 0, 0, '0);
        send_sample(24'sd12, 1, 0, '0);
        idle_input(); drain();
        write_reg(wtmp_pkg::REG_USE_MAG, 1);
        write_reg(wtmp_pkg::REG_TAKE_RECIP, 1);
        send_sample(24'sh800000, 1, 0, '0);
        idle_input(); drain();
        set_all(0, 2, 1, 0, 0, 10, 3);
        send_sample(24'sd100, 0, 0, '0);
        send_sample(24'sd100, 1, 0, '0);
        idle_input(); drain();

        set_all(0, 1, 0, 0, 0, 2, 5);
        send_sample(24'sd50, 0, 0, '0);
        send_sample(24'sd60, 0, 0, '0);
        send_sample(24'sd70, 0, 0, '0);
        idle_input(); drain();
        write_reg(wtmp_pkg::REG_EXPONENT, 2);
        write_reg(wtmp_pkg::REG_USE_MAG, 1);
        send_sample(-24'sd80, 0, 0, '0);
        send_sample(24'sd90, 1, 0, '0);
        idle_input(); drain();

        set_all(1, 2, 0, 0, 1, 200, 210);
        send_trace(220);
        idle_input(); drain();

        while (items_sent < 1100) begin
            random_config();
            repeat ($urandom_range(2, 6)) send_trace($urandom_range(1, 30));
            if ($urandom_range(0, 3) == 0) begin
                idle_input();
                drain();
            end
            idle_input();
            drain();
            if (!hold_req && $urandom_range(0, 9) == 0) begin
                hold_req = 1;
                repeat (4) send_trace($urandom_range(1, 6));
                idle_input();
                drain();
            end
        end

        hold_req = 1;
        repeat (5) send_trace($urandom_range(1, 5));
        idle_input();
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && level_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
